### sv/szc_pkg.sv
// ----------------------------------------------------------------------------
// szc_pkg: shared types and constants of the sky-to-zenithal converter
// Fixed-point widths, CORDIC arctangent table, Q30 product rounding and
// configuration register indexes.
// ----------------------------------------------------------------------------
package szc_pkg;

	// Number of CORDIC micro-rotations and of square root digit steps.
	localparam int CORDIC_STEPS = 32;
	localparam int SQRT_STEPS   = 32;

	// Q30 vector components, vectoring datapath and 32-bit-turn angles.
	localparam int DW = 34;
	localparam int VW = 36;
	localparam int AW = 34;

	typedef logic signed [DW-1:0] q30_t;
	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [AW-1:0] turn_t;

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;
	localparam turn_t       HALF_TURN    = 34'sd2147483648;
	localparam q30_t        INV_GAIN     = 34'sd652032874;
	localparam logic [63:0] POLE_R2      = 64'd2305843008;

	// Configuration register indexes.
	typedef enum logic {
		REG_ZENITH_RA  = 1'b0,
		REG_ZENITH_DEC = 1'b1
	} cfg_reg_t;

	// Arctangent of 2^-i in 32-bit fractions of a turn.
	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	function automatic turn_t atan_step(input int i);
		return turn_t'(ATAN_TURNS[i]);
	endfunction

	// Product of two Q30 values rounded to Q30, halves rounding upward.
	function automatic q30_t mul_q30(input q30_t a, input q30_t b);
		logic signed [2*DW-1:0] p;
		logic signed [2*DW-1:0] r;
		p = a * b;
		r = (p + (2*DW)'(536870912)) >>> 30;
		return r[DW-1:0];
	endfunction

endpackage

### sv/sky_to_zenithal_coordinates.sv
// ----------------------------------------------------------------------------
// sky_to_zenithal_coordinates: sky position to zenith angle and azimuth
// Throughput: one position per cycle; every stage is a register of the
// sine/cosine, multiplier, square root or arctangent cell chains.
// The whole pipeline holds only while a finished result waits to be taken.
// Reset clears the zenith registers and all valid bits; data is not reset.
// ----------------------------------------------------------------------------
module sky_to_zenithal_coordinates #(
	parameter int ANGLE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_en,
	input  szc_pkg::cfg_reg_t            cfg_index,
	input  logic [ANGLE_BITS-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ANGLE_BITS-1:0]        right_ascension,
	input  logic signed [ANGLE_BITS-1:0] declination,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ANGLE_BITS-1:0]        zenith_distance,
	output logic signed [ANGLE_BITS-1:0] azimuth_angle,
	output logic                         at_pole
);
	import szc_pkg::*;

	localparam int SINCOS_LAT = CORDIC_STEPS + 2;
	localparam int ATAN_LAT   = CORDIC_STEPS + 2;
	localparam int MUL_LAT    = 7;
	localparam int PIPE_DEPTH = SINCOS_LAT + MUL_LAT + SQRT_STEPS + ATAN_LAT;
	localparam int FLAG_DELAY = SQRT_STEPS + ATAN_LAT;
	localparam logic [ANGLE_BITS-1:0] ZEN_MAX = {1'b1, {(ANGLE_BITS-1){1'b0}}};

	logic                  en;
	logic [ANGLE_BITS-1:0] zra_q, zdec_q;
	logic [31:0]           ra_t, dec_t, zra_t, zdec_t;
	q30_t                  cr, sr, cd, sd, c1, s1, c2, s2;

	q30_t x_s1, y_s1, z_s1, c1_s1, s1_s1, c2_s1, s2_s1;
	q30_t p0_s2, p1_s2, p2_s2, p3_s2, z_s2, c2_s2, s2_s2;
	q30_t x1_s3, y1_s3, z_s3, c2_s3, s2_s3;
	q30_t p0_s4, p1_s4, p2_s4, p3_s4, y1_s4;
	q30_t x2_s5, z2_s5, y1_s5;
	logic signed [2*DW-1:0] sqx_full, sqy_full;
	logic [63:0] sqx_s6, sqy_s6;
	q30_t x2_s6, y1_s6, z2_s6;
	logic [63:0] r2_sum;
	logic [63:0] r2_s7;
	logic        pole_s7;
	q30_t        x2_s7, y1_s7, z2_s7;

	logic [63:0] sq_rem [0:SQRT_STEPS];
	logic [63:0] sq_res [0:SQRT_STEPS];
	q30_t        z2_d   [1:SQRT_STEPS];
	turn_t       az_d   [1:SQRT_STEPS];
	logic        pole_d [1:FLAG_DELAY];
	logic        zpos_d [1:FLAG_DELAY];
	logic        vld_q  [0:PIPE_DEPTH-1];

	turn_t       az_raw, zen_raw;
	logic [31:0] zen32, az32;
	logic [ANGLE_BITS-1:0] zen_out, az_out;
	logic                  out_valid_q;
	logic [ANGLE_BITS-1:0] zen_q, az_q;
	logic                  pole_q;

	// The pipeline advances unless a finished result is waiting.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Zenith registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zra_q  <= '0;
			zdec_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_ZENITH_RA:  zra_q  <= cfg_data;
				REG_ZENITH_DEC: zdec_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Bring every angle to a 32-bit fraction of a turn.
	if (ANGLE_BITS >= 32) begin : g_in_wide
		assign ra_t   = right_ascension[ANGLE_BITS-1 -: 32];
		assign dec_t  = declination[ANGLE_BITS-1 -: 32];
		assign zra_t  = zra_q[ANGLE_BITS-1 -: 32];
		assign zdec_t = zdec_q[ANGLE_BITS-1 -: 32];
	end else begin : g_in_narrow
		assign ra_t   = {right_ascension, {(32-ANGLE_BITS){1'b0}}};
		assign dec_t  = {declination, {(32-ANGLE_BITS){1'b0}}};
		assign zra_t  = {zra_q, {(32-ANGLE_BITS){1'b0}}};
		assign zdec_t = {zdec_q, {(32-ANGLE_BITS){1'b0}}};
	end

	// Sines and cosines of the point and of both rotation angles.
	szc_sincos u_sc_ra (
		.clk(clk), .en(en), .angle(ra_t), .cos_out(cr), .sin_out(sr)
	);
	szc_sincos u_sc_dec (
		.clk(clk), .en(en), .angle(dec_t), .cos_out(cd), .sin_out(sd)
	);
	szc_sincos u_sc_rot_z (
		.clk(clk), .en(en), .angle(32'd0 - zra_t), .cos_out(c1), .sin_out(s1)
	);
	szc_sincos u_sc_rot_y (
		.clk(clk), .en(en), .angle(QUARTER_TURN - zdec_t), .cos_out(c2), .sin_out(s2)
	);

	// Unit vector, both rotations and the squared radial length.
	assign sqx_full = x2_s5 * x2_s5;
	assign sqy_full = y1_s5 * y1_s5;
	assign r2_sum   = sqx_s6 + sqy_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= mul_q30(cr, cd);
			y_s1  <= mul_q30(sr, cd);
			z_s1  <= sd;
			c1_s1 <= c1;
			s1_s1 <= s1;
			c2_s1 <= c2;
			s2_s1 <= s2;

			p0_s2 <= mul_q30(x_s1, c1_s1);
			p1_s2 <= mul_q30(y_s1, s1_s1);
			p2_s2 <= mul_q30(x_s1, s1_s1);
			p3_s2 <= mul_q30(y_s1, c1_s1);
			z_s2  <= z_s1;
			c2_s2 <= c2_s1;
			s2_s2 <= s2_s1;

			x1_s3 <= p0_s2 - p1_s2;
			y1_s3 <= p2_s2 + p3_s2;
			z_s3  <= z_s2;
			c2_s3 <= c2_s2;
			s2_s3 <= s2_s2;

			p0_s4 <= mul_q30(x1_s3, c2_s3);
			p1_s4 <= mul_q30(z_s3, s2_s3);
			p2_s4 <= mul_q30(x1_s3, s2_s3);
			p3_s4 <= mul_q30(z_s3, c2_s3);
			y1_s4 <= y1_s3;

			x2_s5 <= p0_s4 - p1_s4;
			z2_s5 <= p2_s4 + p3_s4;
			y1_s5 <= y1_s4;

			sqx_s6 <= sqx_full[63:0];
			sqy_s6 <= sqy_full[63:0];
			x2_s6  <= x2_s5;
			y1_s6  <= y1_s5;
			z2_s6  <= z2_s5;

			r2_s7   <= r2_sum;
			pole_s7 <= r2_sum < POLE_R2;
			x2_s7   <= x2_s6;
			y1_s7   <= y1_s6;
			z2_s7   <= z2_s6;
		end
	end

	// Radial length: one square root digit per cell.
	assign sq_rem[0] = r2_s7;
	assign sq_res[0] = '0;
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		szc_sqrt_cell #(.STEP(k)) u_cell (
			.clk     (clk),
			.en      (en),
			.rem_in  (sq_rem[k]),
			.res_in  (sq_res[k]),
			.rem_out (sq_rem[k+1]),
			.res_out (sq_res[k+1])
		);
	end

	// Azimuth runs beside the square root; its result then waits.
	szc_atan2 u_atan_az (
		.clk       (clk),
		.en        (en),
		.x_in      (vec_t'(x2_s7)),
		.y_in      (vec_t'(y1_s7)),
		.angle_out (az_raw)
	);

	// Zenith angle from the rotated z and the radial length.
	szc_atan2 u_atan_zen (
		.clk       (clk),
		.en        (en),
		.x_in      (vec_t'(z2_d[SQRT_STEPS])),
		.y_in      (vec_t'($signed({1'b0, sq_res[SQRT_STEPS][31:0]}))),
		.angle_out (zen_raw)
	);

	// Delay lines that keep side data aligned with the cell chains.
	always_ff @(posedge clk) begin
		if (en) begin
			z2_d[1]   <= z2_s7;
			az_d[1]   <= az_raw;
			pole_d[1] <= pole_s7;
			zpos_d[1] <= z2_s7 > 0;
			for (int k = 1; k < SQRT_STEPS; k++) begin
				z2_d[k+1] <= z2_d[k];
				az_d[k+1] <= az_d[k];
			end
			for (int k = 1; k < FLAG_DELAY; k++) begin
				pole_d[k+1] <= pole_d[k];
				zpos_d[k+1] <= zpos_d[k];
			end
		end
	end

	// Valid bits follow the items through the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_DEPTH; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Pole override and clamping of the zenith angle.
	always_comb begin
		if (pole_d[FLAG_DELAY]) begin
			zen32 = zpos_d[FLAG_DELAY] ? 32'd0 : 32'h8000_0000;
			az32  = '0;
		end else begin
			if (zen_raw < 0) begin
				zen32 = '0;
			end else if (zen_raw > HALF_TURN) begin
				zen32 = 32'h8000_0000;
			end else begin
				zen32 = zen_raw[31:0];
			end
			az32 = az_d[SQRT_STEPS][31:0];
		end
	end

	// Scale back to the port width, rounding half up when narrower.
	if (ANGLE_BITS > 32) begin : g_out_wide
		assign zen_out = {zen32, {(ANGLE_BITS-32){1'b0}}};
		assign az_out  = {az32, {(ANGLE_BITS-32){1'b0}}};
	end else if (ANGLE_BITS == 32) begin : g_out_same
		assign zen_out = zen32;
		assign az_out  = az32;
	end else begin : g_out_narrow
		localparam int SH = 32 - ANGLE_BITS;
		logic [32:0] zen_rnd, az_rnd;
		assign zen_rnd = {1'b0, zen32} + (33'd1 << (SH - 1));
		assign az_rnd  = {1'b0, az32} + (33'd1 << (SH - 1));
		assign zen_out = zen_rnd[31:SH];
		assign az_out  = az_rnd[31:SH];
	end

	// Output register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_q[PIPE_DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zen_q  <= zen_out;
			az_q   <= az_out;
			pole_q <= pole_d[FLAG_DELAY];
		end
	end

	assign out_valid       = out_valid_q;
	assign zenith_distance = zen_q;
	assign azimuth_angle   = az_q;
	assign at_pole         = pole_q;

	// A result at the pole has its azimuth forced to zero.
	a_pole_azimuth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_pole |-> azimuth_angle == '0)
		else $error("pole result with nonzero azimuth");

	// The zenith angle never exceeds a half turn.
	a_zenith_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> zenith_distance <= ZEN_MAX)
		else $error("zenith angle beyond half turn");

	// An accepted input enters the first pipeline stage.
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted item lost at pipeline entry");

	// A waiting result freezes the pipeline and blocks new input.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(zenith_distance) && $stable(vld_q[0]))
		else $error("pipeline moved while result was stalled");
endmodule

### sv/szc_rot_cell.sv
// ----------------------------------------------------------------------------
// szc_rot_cell: one registered rotation-mode CORDIC step
// Turns the vector toward the residual angle by atan(2^-STEP).
// ----------------------------------------------------------------------------
module szc_rot_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          en,
	input  szc_pkg::q30_t x_in,
	input  szc_pkg::q30_t y_in,
	input  szc_pkg::turn_t z_in,
	output szc_pkg::q30_t x_out,
	output szc_pkg::q30_t y_out,
	output szc_pkg::turn_t z_out
);
	import szc_pkg::*;

	q30_t  dx, dy;
	q30_t  x_q, y_q;
	turn_t z_q;

	// Shifted cross terms, arithmetic so they round toward minus infinity.
	always_comb begin
		dx = y_in >>> STEP;
		dy = x_in >>> STEP;
	end

	// Direction follows the sign of the residual angle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[AW-1]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - atan_step(STEP);
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + atan_step(STEP);
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;
endmodule

### sv/szc_vec_cell.sv
// ----------------------------------------------------------------------------
// szc_vec_cell: one registered vectoring-mode CORDIC step
// Drives y toward zero and accumulates the angle turned through.
// ----------------------------------------------------------------------------
module szc_vec_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           en,
	input  szc_pkg::vec_t  x_in,
	input  szc_pkg::vec_t  y_in,
	input  szc_pkg::turn_t z_in,
	output szc_pkg::vec_t  x_out,
	output szc_pkg::vec_t  y_out,
	output szc_pkg::turn_t z_out
);
	import szc_pkg::*;

	vec_t  dx, dy;
	vec_t  x_q, y_q;
	turn_t z_q;

	always_comb begin
		dx = y_in >>> STEP;
		dy = x_in >>> STEP;
	end

	// A strictly positive y turns clockwise, anything else counterclockwise.
	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in > 0) begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + atan_step(STEP);
			end else begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - atan_step(STEP);
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;
endmodule

### sv/szc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// szc_sqrt_cell: one registered digit step of the floor square root
// Tries one result bit and keeps the remainder when it fits.
// ----------------------------------------------------------------------------
module szc_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rem_in,
	input  logic [63:0] res_in,
	output logic [63:0] rem_out,
	output logic [63:0] res_out
);
	localparam logic [63:0] TRIAL_BIT = 64'd1 << (62 - 2 * STEP);

	logic [63:0] trial;
	logic [63:0] rem_q, res_q;

	assign trial = res_in + TRIAL_BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_in >= trial) begin
				rem_q <= rem_in - trial;
				res_q <= (res_in >> 1) + TRIAL_BIT;
			end else begin
				rem_q <= rem_in;
				res_q <= res_in >> 1;
			end
		end
	end

	assign rem_out = rem_q;
	assign res_out = res_q;
endmodule

### sv/szc_sincos.sv
// ----------------------------------------------------------------------------
// szc_sincos: pipelined cosine and sine of a 32-bit turn angle
// Quadrant reduction, a chain of rotation cells, then quadrant restore.
// ----------------------------------------------------------------------------
module szc_sincos (
	input  logic          clk,
	input  logic          en,
	input  logic [31:0]   angle,
	output szc_pkg::q30_t cos_out,
	output szc_pkg::q30_t sin_out
);
	import szc_pkg::*;

	logic [31:0] rounded;
	logic [1:0]  quad;
	logic [31:0] reduced;

	q30_t       x_s [0:CORDIC_STEPS];
	q30_t       y_s [0:CORDIC_STEPS];
	turn_t      z_s [0:CORDIC_STEPS];
	logic [1:0] q_s [0:CORDIC_STEPS];
	turn_t      z0_q;
	q30_t       cos_q, sin_q;

	// Nearest quadrant and the residual within an eighth turn of it.
	always_comb begin
		rounded = angle + EIGHTH_TURN;
		quad    = rounded[31:30];
		reduced = angle - {quad, 30'b0};
	end

	// Entry register of the chain; the quadrant rides alongside the cells.
	always_ff @(posedge clk) begin
		if (en) begin
			z0_q   <= turn_t'($signed(reduced));
			q_s[0] <= quad;
			for (int k = 0; k < CORDIC_STEPS; k++) begin
				q_s[k+1] <= q_s[k];
			end
		end
	end

	// Every rotation starts from the inverse gain on the x axis.
	assign x_s[0] = INV_GAIN;
	assign y_s[0] = '0;
	assign z_s[0] = z0_q;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
		szc_rot_cell #(.STEP(k)) u_cell (
			.clk   (clk),
			.en    (en),
			.x_in  (x_s[k]),
			.y_in  (y_s[k]),
			.z_in  (z_s[k]),
			.x_out (x_s[k+1]),
			.y_out (y_s[k+1]),
			.z_out (z_s[k+1])
		);
	end

	// Rotate the result back into its quadrant.
	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[CORDIC_STEPS])
				2'd0: begin
					cos_q <= x_s[CORDIC_STEPS];
					sin_q <= y_s[CORDIC_STEPS];
				end
				2'd1: begin
					cos_q <= -y_s[CORDIC_STEPS];
					sin_q <= x_s[CORDIC_STEPS];
				end
				2'd2: begin
					cos_q <= -x_s[CORDIC_STEPS];
					sin_q <= -y_s[CORDIC_STEPS];
				end
				default: begin
					cos_q <= y_s[CORDIC_STEPS];
					sin_q <= -x_s[CORDIC_STEPS];
				end
			endcase
		end
	end

	assign cos_out = cos_q;
	assign sin_out = sin_q;
endmodule

### sv/szc_atan2.sv
// ----------------------------------------------------------------------------
// szc_atan2: pipelined four-quadrant arctangent in 32-bit turn units
// Folds the left half plane over, runs a chain of vectoring cells, and
// adds back the half-turn offset. The zero vector gives zero.
// ----------------------------------------------------------------------------
module szc_atan2 (
	input  logic           clk,
	input  logic           en,
	input  szc_pkg::vec_t  x_in,
	input  szc_pkg::vec_t  y_in,
	output szc_pkg::turn_t angle_out
);
	import szc_pkg::*;

	vec_t  x_s    [0:CORDIC_STEPS];
	vec_t  y_s    [0:CORDIC_STEPS];
	turn_t z_s    [0:CORDIC_STEPS];
	turn_t base_s [0:CORDIC_STEPS];
	logic  zero_s [0:CORDIC_STEPS];
	vec_t  x0_q, y0_q;
	turn_t angle_q;

	// Fold x < 0 onto the right half plane and note the offset.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x0_q      <= -x_in;
				y0_q      <= -y_in;
				base_s[0] <= (y_in >= 0) ? HALF_TURN : -HALF_TURN;
			end else begin
				x0_q      <= x_in;
				y0_q      <= y_in;
				base_s[0] <= '0;
			end
			for (int k = 0; k < CORDIC_STEPS; k++) begin
				zero_s[k+1] <= zero_s[k];
				base_s[k+1] <= base_s[k];
			end
		end
	end

	// The angle accumulator of the chain starts at zero.
	assign x_s[0] = x0_q;
	assign y_s[0] = y0_q;
	assign z_s[0] = '0;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
		szc_vec_cell #(.STEP(k)) u_cell (
			.clk   (clk),
			.en    (en),
			.x_in  (x_s[k]),
			.y_in  (y_s[k]),
			.z_in  (z_s[k]),
			.x_out (x_s[k+1]),
			.y_out (y_s[k+1]),
			.z_out (z_s[k+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= zero_s[CORDIC_STEPS] ? '0 : base_s[CORDIC_STEPS] + z_s[CORDIC_STEPS];
		end
	end

	assign angle_out = angle_q;
endmodule
